>>> rtl/core/kaic_pkg.sv
// ----------------------------------------------------------------------------
// kaic_pkg: shared types and constants of the knob, ADC and attach conditioner
// Field widths, register indexes, reset values and the structures that
// pass between the configuration registers, the datapath and the top level.
// ----------------------------------------------------------------------------
package kaic_pkg;

  // Field widths
  localparam int ENC_W   = 16;
  localparam int LEVEL_W = 12;
  localparam int CNT_W   = 8;
  localparam int STEP_W  = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACH_CONFIRM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_CONFIRM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ON      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ON       = 3'd6;

  // Register reset values
  localparam logic [CNT_W-1:0]   RST_ATTACH_CONFIRM = 8'd3;
  localparam logic [STEP_W-1:0]  RST_MAX_STEP       = 15'd32;
  localparam logic [CNT_W-1:0]   RST_DEADBAND       = 8'd1;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_THRESH   = 12'd16;
  localparam logic [CNT_W-1:0]   RST_MODE_CONFIRM   = 8'd8;
  localparam logic [LEVEL_W-1:0] RST_SECOND_ON      = 12'd2800;
  localparam logic [LEVEL_W-1:0] RST_FIRST_ON       = 12'd2200;

  // Saturation limit of the confirmation counters
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Mode codes
  localparam logic MODE_FIRST  = 1'b0;
  localparam logic MODE_SECOND = 1'b1;

  // Configuration register set
  typedef struct packed {
    logic [CNT_W-1:0]   attach_confirm_count;
    logic [STEP_W-1:0]  max_step;
    logic [CNT_W-1:0]   deadband;
    logic [LEVEL_W-1:0] level_change_threshold;
    logic [CNT_W-1:0]   mode_confirm_count;
    logic [LEVEL_W-1:0] second_mode_on_level;
    logic [LEVEL_W-1:0] first_mode_on_level;
  } cfg_t;

  // One poll sample
  typedef struct packed {
    logic [ENC_W-1:0]   encoder_count;
    logic [LEVEL_W-1:0] adc_sample;
    logic               attach_pin;
  } sample_t;

  // One conditioned result
  typedef struct packed {
    logic                    any_change;
    logic signed [ENC_W-1:0] count_step;
    logic [LEVEL_W-1:0]      knob_level;
    logic                    level_report;
    logic                    mode_select;
    logic                    mode_switch;
    logic                    attach_event;
  } result_t;

endpackage

>>> rtl/core/kaic_ifs.sv
// ----------------------------------------------------------------------------
// kaic interfaces: valid/ready channels of the conditioner
// Sample input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------

// Poll sample channel
interface kaic_sample_if;
  logic                          valid;
  logic                          ready;
  logic [kaic_pkg::ENC_W-1:0]    encoder_count;
  logic [kaic_pkg::LEVEL_W-1:0]  adc_sample;
  logic                          attach_pin;

  modport source (output valid, encoder_count, adc_sample, attach_pin, input ready);
  modport sink   (input valid, encoder_count, adc_sample, attach_pin, output ready);
endinterface

// Result channel
interface kaic_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 any_change;
  logic signed [kaic_pkg::ENC_W-1:0]    count_step;
  logic [kaic_pkg::LEVEL_W-1:0]         knob_level;
  logic                                 level_report;
  logic                                 mode_select;
  logic                                 mode_switch;
  logic                                 attach_event;

  modport source (output valid, any_change, count_step, knob_level, level_report,
                  mode_select, mode_switch, attach_event, input ready);
  modport sink   (input valid, any_change, count_step, knob_level, level_report,
                  mode_select, mode_switch, attach_event, output ready);
endinterface

// Configuration write channel
interface kaic_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kaic_pkg::CFG_IDX_W-1:0]    index;
  logic [kaic_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/kaic_cfg_regs.sv
// ----------------------------------------------------------------------------
// kaic_cfg_regs: configuration register file
// Holds the seven tuning registers; a write transfer updates one of them and
// an index beyond the list is dropped.
// ----------------------------------------------------------------------------
module kaic_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  kaic_cfg_if.sink         cfg,
  output kaic_pkg::cfg_t   regs
);
  import kaic_pkg::*;

  // The register file is always able to take a write.
  assign cfg.ready = 1'b1;

  // Register writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attach_confirm_count   <= RST_ATTACH_CONFIRM;
      regs.max_step               <= RST_MAX_STEP;
      regs.deadband               <= RST_DEADBAND;
      regs.level_change_threshold <= RST_LEVEL_THRESH;
      regs.mode_confirm_count     <= RST_MODE_CONFIRM;
      regs.second_mode_on_level   <= RST_SECOND_ON;
      regs.first_mode_on_level    <= RST_FIRST_ON;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ATTACH_CONFIRM: regs.attach_confirm_count   <= cfg.data[CNT_W-1:0];
        REG_MAX_STEP:       regs.max_step               <= cfg.data[STEP_W-1:0];
        REG_DEADBAND:       regs.deadband               <= cfg.data[CNT_W-1:0];
        REG_LEVEL_THRESH:   regs.level_change_threshold <= cfg.data[LEVEL_W-1:0];
        REG_MODE_CONFIRM:   regs.mode_confirm_count     <= cfg.data[CNT_W-1:0];
        REG_SECOND_ON:      regs.second_mode_on_level   <= cfg.data[LEVEL_W-1:0];
        REG_FIRST_ON:       regs.first_mode_on_level    <= cfg.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/kaic_core.sv
// ----------------------------------------------------------------------------
// kaic_core: conditioning datapath and its state
// Computes one result from the registered sample and the running state, and
// updates the state when the result is loaded into the output register.
// ----------------------------------------------------------------------------
module kaic_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  kaic_pkg::sample_t   item,
  input  kaic_pkg::cfg_t      regs,
  output kaic_pkg::result_t   res
);
  import kaic_pkg::*;

  // Running state
  logic               primed;
  logic [ENC_W-1:0]   last_count;
  logic               attach_state;
  logic [CNT_W-1:0]   attach_count;
  logic [LEVEL_W-1:0] filtered_level;
  logic [LEVEL_W-1:0] reported_level;
  logic [CNT_W-1:0]   mode_count;
  logic               current_mode;

  logic               attach_state_next;
  logic [CNT_W-1:0]   attach_count_next;
  logic [LEVEL_W-1:0] filtered_level_next;
  logic [LEVEL_W-1:0] reported_level_next;
  logic [CNT_W-1:0]   mode_count_next;
  logic               current_mode_next;

  // Working values
  logic                    inserted;
  logic [ENC_W-1:0]        base_count;
  logic                    base_attach;
  logic [CNT_W-1:0]        base_attach_cnt;
  logic [LEVEL_W-1:0]      base_filt;
  logic [LEVEL_W-1:0]      base_rep;
  logic [CNT_W-1:0]        base_mode_cnt;
  logic                    base_mode;
  logic [CNT_W-1:0]        attach_inc;
  logic [CNT_W-1:0]        mode_inc;
  logic                    attach_ev;
  logic [STEP_W-1:0]       filt_sum;
  logic [ENC_W-1:0]        diff;
  logic signed [ENC_W:0]   wide_diff;
  logic signed [ENC_W:0]   limit;
  logic signed [ENC_W:0]   clamped;
  logic signed [ENC_W:0]   magnitude;
  logic signed [ENC_W-1:0] delta;
  logic [LEVEL_W-1:0]      level_dist;
  logic                    adc_upd;
  logic                    target;
  logic                    mode_req;
  logic                    req_mode;

  always_comb begin
    inserted = ~item.attach_pin;

    // The first sample after reset seeds the state it is then compared with.
    base_count      = primed ? last_count     : item.encoder_count;
    base_attach     = primed ? attach_state   : inserted;
    base_attach_cnt = primed ? attach_count   : '0;
    base_filt       = primed ? filtered_level : item.adc_sample;
    base_rep        = primed ? reported_level : item.adc_sample;
    base_mode_cnt   = primed ? mode_count     : '0;
    base_mode       = primed ? current_mode   : MODE_FIRST;

    // Attach debounce: a differing pin level must persist for the confirm count.
    attach_inc        = (base_attach_cnt == CNT_MAX) ? base_attach_cnt
                                                     : base_attach_cnt + 1'b1;
    attach_state_next = base_attach;
    attach_count_next = '0;
    attach_ev         = 1'b0;
    if (inserted != base_attach) begin
      if (attach_inc >= regs.attach_confirm_count) begin
        attach_state_next = inserted;
        attach_ev         = inserted;
      end else begin
        attach_count_next = attach_inc;
      end
    end

    // 7/8 IIR: (7 * level + sample) / 8, never beyond 15 bits.
    filt_sum = ({3'b000, base_filt} << 3) - {3'b000, base_filt}
             + {3'b000, item.adc_sample};
    filtered_level_next = filt_sum[STEP_W-1:3];

    // Wrapped counter delta, clamped to the step limit, then deadbanded.
    diff      = item.encoder_count - base_count;
    wide_diff = {diff[ENC_W-1], diff};
    limit     = {2'b00, regs.max_step};
    if (wide_diff > limit) begin
      clamped = limit;
    end else if (wide_diff < -limit) begin
      clamped = -limit;
    end else begin
      clamped = wide_diff;
    end
    magnitude = (clamped < 0) ? -clamped : clamped;
    if (magnitude <= $signed({{(ENC_W+1-CNT_W){1'b0}}, regs.deadband})) begin
      delta = '0;
    end else begin
      delta = clamped[ENC_W-1:0];
    end

    // Level report once the filtered level has moved far enough.
    level_dist = (filtered_level_next > base_rep) ? filtered_level_next - base_rep
                                                  : base_rep - filtered_level_next;
    adc_upd = (filtered_level_next != base_rep) &&
              (level_dist >= regs.level_change_threshold);
    reported_level_next = adc_upd ? filtered_level_next : base_rep;

    // Mode hysteresis with a confirmation count.
    target = base_mode;
    if (base_mode == MODE_FIRST) begin
      if (filtered_level_next >= regs.second_mode_on_level) target = MODE_SECOND;
    end else begin
      if (filtered_level_next <= regs.first_mode_on_level) target = MODE_FIRST;
    end
    mode_inc          = (base_mode_cnt == CNT_MAX) ? base_mode_cnt : base_mode_cnt + 1'b1;
    current_mode_next = base_mode;
    mode_count_next   = '0;
    mode_req          = 1'b0;
    req_mode          = MODE_FIRST;
    if (target != base_mode) begin
      if (mode_inc >= regs.mode_confirm_count) begin
        current_mode_next = target;
        mode_req          = 1'b1;
        req_mode          = target;
      end else begin
        mode_count_next = mode_inc;
      end
    end

    // Result
    res.any_change   = (delta != '0) || adc_upd || mode_req || attach_ev;
    res.count_step   = delta;
    res.knob_level   = filtered_level_next;
    res.level_report = adc_upd;
    res.mode_select  = req_mode;
    res.mode_switch  = mode_req;
    res.attach_event = attach_ev;
  end

  // State update, one sample per load.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed         <= 1'b0;
      last_count     <= '0;
      attach_state   <= 1'b0;
      attach_count   <= '0;
      filtered_level <= '0;
      reported_level <= '0;
      mode_count     <= '0;
      current_mode   <= MODE_FIRST;
    end else if (load) begin
      primed         <= 1'b1;
      last_count     <= item.encoder_count;
      attach_state   <= attach_state_next;
      attach_count   <= attach_count_next;
      filtered_level <= filtered_level_next;
      reported_level <= reported_level_next;
      mode_count     <= mode_count_next;
      current_mode   <= current_mode_next;
    end
  end

endmodule

>>> rtl/core/knob_adc_attach_input_conditioner_top.sv
// ----------------------------------------------------------------------------
// knob_adc_attach_input_conditioner_top: knob, ADC and attach conditioner
// Turns poll samples into clamped encoder deltas, a filtered knob level with
// change reports, debounced attach events and hysteretic mode requests.
// ----------------------------------------------------------------------------
// Usage:
//   samples : valid/ready channel, one poll sample (encoder_count, adc_sample,
//             attach_pin) per transfer.
//   results : valid/ready channel, exactly one result per accepted sample,
//             in order.
//   cfg     : write channel, index 0..6 selects a tuning register; always
//             ready. Write only while no sample is in flight.
// A sample transfer loads the input register; once the result register is
// free, the sample moves on and its result is loaded into the result
// register, from which it is offered. The datapath is a single combinational
// pass between them, so while the receiver does not stall one sample per
// clock is taken and one result per clock is delivered.
// While the receiver stalls, the held result stays in the output register and
// one further sample can still be taken into the input register; after that
// samples.ready falls until the result is taken.
// A synchronous reset empties both registers, restores the register defaults
// and clears the running state; the first sample afterwards seeds it.
// ----------------------------------------------------------------------------
module knob_adc_attach_input_conditioner_top (
  input  logic          clk,
  input  logic          rst,
  kaic_sample_if.sink   samples,
  kaic_result_if.source results,
  kaic_cfg_if.sink      cfg
);
  import kaic_pkg::*;

  cfg_t    regs;
  sample_t s1_item;
  logic    s1_valid;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    s2_free;
  logic    s1_adv;
  logic    in_xfer;

  // Configuration registers
  kaic_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake between the input register and the result register.
  assign s2_free       = !out_valid || results.ready;
  assign s1_adv        = s1_valid && s2_free;
  assign samples.ready = !s1_valid || s2_free;
  assign in_xfer       = samples.valid && samples.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item.encoder_count <= samples.encoder_count;
      s1_item.adc_sample    <= samples.adc_sample;
      s1_item.attach_pin    <= samples.attach_pin;
    end
  end

  // Datapath and running state
  kaic_core u_core (
    .clk  (clk),
    .rst  (rst),
    .load (s1_adv),
    .item (s1_item),
    .regs (regs),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= core_res;
    end
  end

  assign results.valid        = out_valid;
  assign results.any_change   = out_res.any_change;
  assign results.count_step   = out_res.count_step;
  assign results.knob_level   = out_res.knob_level;
  assign results.level_report = out_res.level_report;
  assign results.mode_select  = out_res.mode_select;
  assign results.mode_switch  = out_res.mode_switch;
  assign results.attach_event = out_res.attach_event;

  // A sample taken in is held until it moves on to the result register.
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid)
    else $error("sample lost from the input register");

  // A transfer on the sample channel always fills the input register.
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted sample not registered");

  // Moving a sample on always presents a result in the next cycle.
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> results.valid)
    else $error("result missing after datapath pass");

  // Reset leaves no result on the output channel.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !results.valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> tb/sv/tb_knob_adc_attach_input_conditioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_knob_adc_attach_input_conditioner_top: self-checking bench of the
// knob, ADC and attach conditioner
// A short table of directed samples runs first, at the register defaults.
// Several register settings follow, with random sample streams under each.
// The settings include both ends of every register, the zero confirm counts
// and a zero step limit. Each accepted sample is run through a local copy of
// the conditioning rules. The expected result is queued and compared field
// by field with the block's output. The sender idles in bursts and the
// receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_knob_adc_attach_input_conditioner_top;
  import kaic_pkg::*;

  localparam int          N_DIRECTED      = 25;
  localparam int          N_PHASES        = 8;
  localparam int          ITEMS_PER_PHASE = 150;
  localparam int          PHASE_MAX       = 0;
  localparam int          PHASE_MIN       = 1;
  localparam int          PHASE_SPECIAL   = 2;
  localparam int          PHASE_PRESSURE  = 3;
  localparam int          DRAIN_CYCLES    = 4;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          MAX_REPORTS     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // One row of the directed table; exp is only used where typed is set.
  typedef struct packed {
    sample_t s;
    bit      typed;
    result_t exp;
  } dir_row_t;

  localparam result_t NO_CHECK = '0;

  logic clk;
  logic rst;

  kaic_sample_if samples_ch ();
  kaic_result_if results_ch ();
  kaic_cfg_if    cfg_ch ();

  knob_adc_attach_input_conditioner_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  // Directed samples. The first rows follow reset at the default registers:
  // seeding, both delta extremes, the wrap and the deadband. Later rows cover
  // a mode switch each way, an insertion, a pin glitch and a release.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{16'h8000, 12'd4095, 1'b1}, 1'b1, '{1'b0, 16'sd0, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{16'h0000, 12'd4095, 1'b1}, 1'b1, '{1'b1, -16'sd32, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{16'h7FFF, 12'd4095, 1'b1}, 1'b1, '{1'b1, 16'sd32, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{16'h8000, 12'd4095, 1'b1}, 1'b1, '{1'b0, 16'sd0, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{16'h8002, 12'd4095, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b1}, 1'b0, NO_CHECK},
    '{'{16'h8002, 12'd4095, 1'b0}, 1'b0, NO_CHECK},
    '{'{16'hFFFF, 12'd0,    1'b0}, 1'b0, NO_CHECK},
    '{'{16'h0001, 12'd0,    1'b0}, 1'b0, NO_CHECK},
    '{'{16'h0001, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0001, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0001, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0005, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0005, 12'd0,    1'b0}, 1'b0, NO_CHECK},
    '{'{16'h0005, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0005, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'h0105, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'hFF05, 12'd0,    1'b1}, 1'b0, NO_CHECK},
    '{'{16'hFF05, 12'd0,    1'b1}, 1'b0, NO_CHECK}
  };

  // Local copy of the registers and running state of the conditioner.
  cfg_t               regs;
  logic               seen_first;
  logic [ENC_W-1:0]   prev_count;
  logic               attached;
  logic [CNT_W-1:0]   attach_run;
  logic [LEVEL_W-1:0] filt_level;
  logic [LEVEL_W-1:0] report_level;
  logic [CNT_W-1:0]   mode_run;
  logic               active_mode;

  result_t expected_results [$];
  int      mismatch_count = 0;
  int      result_count   = 0;
  int      cycle_count    = 0;
  int      burst_left     = 0;

  // Random walk state of the stimulus.
  logic [ENC_W-1:0] enc_pos      = '0;
  int               level_target = 2048;
  logic             pin_level    = 1'b1;
  int               pin_run      = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected result of one sample; advances the local state.
  function automatic result_t predict_conditioned(input sample_t s);
    result_t          r;
    logic             inserted;
    logic             target;
    logic [ENC_W-1:0] diff;
    int               v;
    int               lim;
    int               db;
    int               lvl;
    r        = '0;
    inserted = ~s.attach_pin;
    // The first sample after reset seeds the state, then runs as normal.
    if (!seen_first) begin
      prev_count   = s.encoder_count;
      attached     = inserted;
      attach_run   = '0;
      filt_level   = s.adc_sample;
      report_level = s.adc_sample;
      mode_run     = '0;
      active_mode  = MODE_FIRST;
      seen_first   = 1'b1;
    end
    // Attach debounce; only an insertion raises the event.
    if (inserted == attached) begin
      attach_run = '0;
    end else begin
      if (attach_run != CNT_MAX) attach_run++;
      if (attach_run >= regs.attach_confirm_count) begin
        attached       = inserted;
        attach_run     = '0;
        r.attach_event = inserted;
      end
    end
    // Seven-eighths IIR filter.
    lvl        = (int'(filt_level) * 7 + int'(s.adc_sample)) >> 3;
    filt_level = lvl[LEVEL_W-1:0];
    // Wrapped delta, clamped to the step limit, then the deadband.
    diff = s.encoder_count - prev_count;
    v    = int'($signed(diff));
    lim  = int'(regs.max_step);
    db   = int'(regs.deadband);
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    if (v <= db && v >= -db) v = 0;
    prev_count   = s.encoder_count;
    r.count_step = v[ENC_W-1:0];
    // Level report once the move since the last report reaches the threshold.
    if ((filt_level > report_level &&
         filt_level - report_level >= regs.level_change_threshold) ||
        (report_level > filt_level &&
         report_level - filt_level >= regs.level_change_threshold)) begin
      r.level_report = 1'b1;
      report_level   = filt_level;
    end
    // Mode hysteresis with a confirmation count.
    target = active_mode;
    if (active_mode == MODE_FIRST) begin
      if (filt_level >= regs.second_mode_on_level) target = MODE_SECOND;
    end else begin
      if (filt_level <= regs.first_mode_on_level) target = MODE_FIRST;
    end
    if (target != active_mode) begin
      if (mode_run != CNT_MAX) mode_run++;
      if (mode_run >= regs.mode_confirm_count) begin
        active_mode   = target;
        mode_run      = '0;
        r.mode_switch = 1'b1;
        r.mode_select = target;
      end
    end else begin
      mode_run = '0;
    end
    r.knob_level = filt_level;
    r.any_change = (v != 0) || r.level_report || r.mode_switch || r.attach_event;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // One register write; the local copy is masked to the register width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ATTACH_CONFIRM: regs.attach_confirm_count   = value[CNT_W-1:0];
      REG_MAX_STEP:       regs.max_step               = value[STEP_W-1:0];
      REG_DEADBAND:       regs.deadband               = value[CNT_W-1:0];
      REG_LEVEL_THRESH:   regs.level_change_threshold = value[LEVEL_W-1:0];
      REG_MODE_CONFIRM:   regs.mode_confirm_count     = value[CNT_W-1:0];
      REG_SECOND_ON:      regs.second_mode_on_level   = value[LEVEL_W-1:0];
      REG_FIRST_ON:       regs.first_mode_on_level    = value[LEVEL_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_ATTACH_CONFIRM, CFG_DATA_W'(c.attach_confirm_count));
    write_reg(REG_MAX_STEP,       CFG_DATA_W'(c.max_step));
    write_reg(REG_DEADBAND,       CFG_DATA_W'(c.deadband));
    write_reg(REG_LEVEL_THRESH,   CFG_DATA_W'(c.level_change_threshold));
    write_reg(REG_MODE_CONFIRM,   CFG_DATA_W'(c.mode_confirm_count));
    write_reg(REG_SECOND_ON,      CFG_DATA_W'(c.second_mode_on_level));
    write_reg(REG_FIRST_ON,       CFG_DATA_W'(c.first_mode_on_level));
  endtask

  // Register set of a phase: both extremes first, random ones afterwards.
  function automatic cfg_t settings_for_phase(input int p);
    cfg_t c;
    case (p)
      PHASE_MAX: c = '{8'd255, 15'd32767, 8'd255, 12'd4095, 8'd255, 12'd4095, 12'd4095};
      PHASE_MIN: c = '{8'd1, 15'd1, 8'd0, 12'd1, 8'd1, 12'd0, 12'd0};
      default: begin
        c.attach_confirm_count = CNT_W'($urandom_range(1, 6));
        c.max_step = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(1, 32767))
                                                  : STEP_W'($urandom_range(1, 200));
        c.deadband = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 255))
                                                  : CNT_W'($urandom_range(0, 4));
        c.level_change_threshold = ($urandom_range(0, 1) == 0) ?
                                   LEVEL_W'($urandom_range(1, 64)) :
                                   LEVEL_W'($urandom_range(1, 4095));
        c.mode_confirm_count   = CNT_W'($urandom_range(1, 10));
        c.second_mode_on_level = LEVEL_W'($urandom_range(1500, 4095));
        c.first_mode_on_level  = LEVEL_W'($urandom_range(0, c.second_mode_on_level));
      end
    endcase
    return c;
  endfunction

  // Random sample: a wandering counter, a level held near a target with noise,
  // and a pin held for runs with short glitches.
  task automatic next_random_sample(output sample_t s);
    int span;
    int step;
    int lvl;
    if ($urandom_range(0, 99) < 5) begin
      enc_pos = ENC_W'($urandom);
    end else begin
      span    = ($urandom_range(0, 3) == 0) ? 700 : 40;
      step    = $urandom_range(0, 2 * span) - span;
      enc_pos = enc_pos + ENC_W'(step);
    end
    if ($urandom_range(0, 29) == 0) begin
      case ($urandom_range(0, 3))
        0:       level_target = 0;
        1:       level_target = 4095;
        default: level_target = $urandom_range(0, 4095);
      endcase
    end
    if ($urandom_range(0, 19) == 0) lvl = $urandom_range(0, 4095);
    else lvl = level_target + $urandom_range(0, 16) - 8;
    if (lvl < 0) lvl = 0;
    if (lvl > 4095) lvl = 4095;
    if (pin_run == 0) begin
      pin_level = ~pin_level;
      pin_run   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
    end
    pin_run--;
    s.encoder_count = enc_pos;
    s.adc_sample    = LEVEL_W'(lvl);
    s.attach_pin    = pin_level;
  endtask

  // Sender bursts: at the end of a burst, valid drops for a random gap.
  task automatic idle_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
  endtask

  // Offer one sample and queue its expected result on transfer.
  task automatic send_item(input sample_t s, input bit typed, input result_t typed_exp);
    result_t predicted;
    samples_ch.valid         <= 1'b1;
    samples_ch.encoder_count <= s.encoder_count;
    samples_ch.adc_sample    <= s.adc_sample;
    samples_ch.attach_pin    <= s.attach_pin;
    do @(posedge clk); while (!samples_ch.ready);
    predicted = predict_conditioned(s);
    expected_results.push_back(typed ? typed_exp : predicted);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic settle_block();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: the stall rate is picked anew whenever stall_left runs out.
  initial begin : receiver
    int stall_pct;
    int stall_left;
    stall_pct  = 0;
    stall_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_left = 128;
      end
      stall_left--;
      results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker: each transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with no sample outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("any_change", results_ch.any_change, want.any_change);
        check_field("count_step", results_ch.count_step, want.count_step);
        check_field("knob_level", results_ch.knob_level, want.knob_level);
        check_field("level_report", results_ch.level_report, want.level_report);
        check_field("mode_select", results_ch.mode_select, want.mode_select);
        check_field("mode_switch", results_ch.mode_switch, want.mode_switch);
        check_field("attach_event", results_ch.attach_event, want.attach_event);
      end
      result_count++;
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_knob_adc_attach_input_conditioner_top: FAIL");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    sample_t s;
    regs = '{RST_ATTACH_CONFIRM, RST_MAX_STEP, RST_DEADBAND, RST_LEVEL_THRESH,
             RST_MODE_CONFIRM, RST_SECOND_ON, RST_FIRST_ON};
    seen_first   = 1'b0;
    prev_count   = '0;
    attached     = 1'b0;
    attach_run   = '0;
    filt_level   = '0;
    report_level = '0;
    mode_run     = '0;
    active_mode  = MODE_FIRST;

    rst                      <= 1'b1;
    samples_ch.valid         <= 1'b0;
    samples_ch.encoder_count <= '0;
    samples_ch.adc_sample    <= '0;
    samples_ch.attach_pin    <= 1'b1;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= '0;
    cfg_ch.data              <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset defaults.
    foreach (directed_rows[k]) begin
      idle_gap();
      send_item(directed_rows[k].s, directed_rows[k].typed, directed_rows[k].exp);
    end

    // Random phases, each under its own register set.
    for (int p = 0; p < N_PHASES; p++) begin
      settle_block();
      if (p == PHASE_SPECIAL) begin
        // Zero confirm counts, zero step limit and zero threshold, reached
        // through masking of the upper data bits; the unused index is ignored.
        write_reg(REG_ATTACH_CONFIRM, 16'h0000);
        write_reg(REG_MAX_STEP,       16'h8000);
        write_reg(REG_DEADBAND,       16'hFF00);
        write_reg(REG_LEVEL_THRESH,   16'hF000);
        write_reg(REG_MODE_CONFIRM,   16'h0100);
        write_reg(REG_SECOND_ON,      16'hFABC);
        write_reg(REG_FIRST_ON,       16'h1234);
        write_reg(REG_NONE,           16'hFFFF);
      end else begin
        apply_settings(settings_for_phase(p));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == PHASE_PRESSURE && i == ITEMS_PER_PHASE / 2) settle_block();
        idle_gap();
        next_random_sample(s);
        send_item(s, 1'b0, NO_CHECK);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("tb_knob_adc_attach_input_conditioner_top: PASS");
    end else begin
      $display("tb_knob_adc_attach_input_conditioner_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/kaic_pkg.sv
rtl/core/kaic_ifs.sv
rtl/core/kaic_cfg_regs.sv
rtl/core/kaic_core.sv
rtl/core/knob_adc_attach_input_conditioner_top.sv
tb/sv/tb_knob_adc_attach_input_conditioner_top.sv
